### sv/io_status_rate_limited_aggregator_defines.svh
// ----------------------------------------------------------------------------
// I/O status aggregator assertion macros
// Short forms for the concurrent checks of the port checker. Each macro
// expects signals named clk and rst_n where it is used.
// ----------------------------------------------------------------------------
`ifndef IO_STATUS_RATE_LIMITED_AGGREGATOR_DEFINES_SVH
`define IO_STATUS_RATE_LIMITED_AGGREGATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IOSRA_ASSERT_IMPL(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IOSRA_ASSERT_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

### sv/iosra_pkg.sv
// ----------------------------------------------------------------------------
// I/O status aggregator package
// Beat types, the decoded item that travels from the front to the back end,
// and the constants of the status frame.
// ----------------------------------------------------------------------------
package iosra_pkg;

  // Default sizes handed to the top level.
  localparam int TIME_BITS_DEF    = 32;
  localparam int COUNTER_BITS_DEF = 16;

  // Rate-limited input channels: four shared channels and two digital ones.
  localparam int NUM_CH      = 6;
  localparam int NUM_AIN     = 4;
  localparam int FRAME_LEN   = 25;
  localparam int QUEUE_DEPTH = 2;
  localparam int IV_BITS     = 32;

  // Pin selector ranges.
  localparam logic [4:0] PIN_DO_LAST = 5'd3;
  localparam logic [4:0] PIN_AO      = 5'd4;
  localparam logic [4:0] PIN_DI_BASE = 5'd5;
  localparam logic [4:0] PIN_DI_LAST = 5'd10;
  localparam logic [4:0] PIN_AV_BASE = 5'd11;
  localparam logic [4:0] PIN_AV_LAST = 5'd14;
  localparam logic [4:0] PIN_AI_BASE = 5'd15;
  localparam logic [4:0] PIN_AI_LAST = 5'd18;

  // Value and mode constants.
  localparam logic [15:0] HIGH_MILLI   = 16'd1000;
  localparam logic [15:0] ANALOG_RESET = 16'hffff;
  localparam logic [7:0]  MODE_DI_MASK = 8'b10000000;
  localparam logic [7:0]  MODE_AI_MASK = 8'b01000000;

  // Operation classes found by the front end.
  typedef enum logic [2:0] {
    OP_READ,
    OP_DOUT,
    OP_AOUT,
    OP_DIN,
    OP_AV,
    OP_AI,
    OP_NONE
  } op_t;

  // Input beat.
  typedef struct packed {
    logic        command;
    logic [4:0]  pin_select;
    logic [15:0] value_milli;
    logic [31:0] now_ms;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic       updates_pending;
    logic       accepted;
  } out_beat_t;

  // Decoded item held in the queue.
  typedef struct packed {
    op_t         op;
    logic [2:0]  ch;
    logic        high;
    logic [15:0] value;
    logic [31:0] now_ms;
  } item_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

### sv/iosra_front.sv
// ----------------------------------------------------------------------------
// I/O status aggregator front end
// Classifies each input beat by command and pin selector and places the
// decoded item in a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module iosra_front
  import iosra_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_beat_t in_data,
  output head_t    head,
  input  logic     pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            dec;
  item_t            q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;

  // Decode the beat into an operation class and a channel number.
  always_comb begin
    dec.op     = OP_NONE;
    dec.ch     = 3'd0;
    dec.high   = (in_data.value_milli == HIGH_MILLI);
    dec.value  = in_data.value_milli;
    dec.now_ms = in_data.now_ms;
    priority if (in_data.command) begin
      dec.op = OP_READ;
    end else if (in_data.pin_select <= PIN_DO_LAST) begin
      dec.op = OP_DOUT;
      dec.ch = in_data.pin_select[2:0];
    end else if (in_data.pin_select == PIN_AO) begin
      dec.op = OP_AOUT;
    end else if (in_data.pin_select <= PIN_DI_LAST) begin
      dec.op = OP_DIN;
      dec.ch = 3'(in_data.pin_select - PIN_DI_BASE);
    end else if (in_data.pin_select <= PIN_AV_LAST) begin
      dec.op = OP_AV;
      dec.ch = 3'(in_data.pin_select - PIN_AV_BASE);
    end else if (in_data.pin_select <= PIN_AI_LAST) begin
      dec.op = OP_AI;
      dec.ch = 3'(in_data.pin_select - PIN_AI_BASE);
    end else begin
      dec.op = OP_NONE;
    end
  end

  // The queue refuses beats only when both entries are occupied.
  assign in_stall = (count_r == CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head.valid = (count_r != '0);
  assign head.item  = q_r[rd_ptr_r];

endmodule

### sv/iosra_back.sv
// ----------------------------------------------------------------------------
// I/O status aggregator back end
// Holds the status image, applies rate limits and updates for events, and
// streams the 25-byte status frame for read commands through the output
// register.
// ----------------------------------------------------------------------------
module iosra_back
  import iosra_pkg::*;
#(
  parameter int TIME_BITS    = TIME_BITS_DEF,
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  head_t                           head,
  output logic                            pop,
  input  logic [NUM_CH-1:0][IV_BITS-1:0]  min_iv,
  output logic                            out_valid,
  input  logic                            out_stall,
  output out_beat_t                       out_data
);

  localparam int CMP_W  = (TIME_BITS > IV_BITS) ? TIME_BITS : IV_BITS;
  localparam int FIDX_W = $clog2(FRAME_LEN);

  // Status image.
  logic [7:0]              mode_r;
  logic [3:0]              out_lvl_r;
  logic [15:0]             ao_r;
  logic [NUM_CH-1:0]       in_lvl_r;
  logic [15:0]             ai_r   [NUM_AIN];
  logic [COUNTER_BITS-1:0] cnt_r  [NUM_CH];
  logic [NUM_CH-1:0]       never_r;
  logic [TIME_BITS-1:0]    last_r [NUM_CH];
  logic                    changed_r;
  logic [FIDX_W-1:0]       fidx_r;

  // Output register.
  logic      out_valid_r;
  out_beat_t out_data_r;

  item_t                   it;
  logic                    go;
  logic                    is_read;
  logic                    is_input;
  logic                    last_fbyte;
  logic [TIME_BITS-1:0]    now_tb;
  logic [TIME_BITS-1:0]    diff;
  logic                    pass;
  logic                    take;
  logic                    acc;
  logic                    changed_nxt;
  logic [FRAME_LEN-1:0][7:0] frame_img;

  assign it         = head.item;
  assign go         = head.valid && (!out_valid_r || !out_stall);
  assign is_read    = (it.op == OP_READ);
  assign is_input   = (it.op == OP_DIN) || (it.op == OP_AV) || (it.op == OP_AI);
  assign last_fbyte = (fidx_r == FIDX_W'(FRAME_LEN - 1));
  assign pop        = go && (!is_read || last_fbyte);

  // Rate limit: first event of the channel, or wrapping age at least the interval.
  assign now_tb = TIME_BITS'(it.now_ms);
  assign diff   = now_tb - last_r[it.ch];
  assign pass   = never_r[it.ch] || (CMP_W'(diff) >= CMP_W'(min_iv[it.ch]));
  assign take   = is_input && pass;

  // Output and analog output events always pass.
  assign acc         = (it.op == OP_DOUT) || (it.op == OP_AOUT) || take;
  assign changed_nxt = changed_r || acc;

  // Status frame image in transmit order.
  always_comb begin
    frame_img[0] = mode_r;
    frame_img[1] = {4'd0, out_lvl_r};
    frame_img[2] = ao_r[15:8];
    frame_img[3] = ao_r[7:0];
    frame_img[4] = {2'd0, in_lvl_r};
    for (int i = 0; i < NUM_AIN; i++) begin
      frame_img[5 + 2 * i] = ai_r[i][15:8];
      frame_img[6 + 2 * i] = ai_r[i][7:0];
    end
    for (int i = 0; i < NUM_CH; i++) begin
      frame_img[13 + 2 * i] = 8'(16'(cnt_r[i]) >> 8);
      frame_img[14 + 2 * i] = 8'(16'(cnt_r[i]));
    end
  end

  // Image updates for events; a read only clears the updates flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= '0;
      out_lvl_r <= '0;
      ao_r      <= ANALOG_RESET;
      in_lvl_r  <= '0;
      never_r   <= '1;
      changed_r <= 1'b1;
      for (int i = 0; i < NUM_AIN; i++) begin
        ai_r[i] <= ANALOG_RESET;
      end
      for (int i = 0; i < NUM_CH; i++) begin
        last_r[i] <= '0;
      end
    end else if (go) begin
      if (is_read) begin
        changed_r <= 1'b0;
      end else begin
        changed_r <= changed_nxt;
        unique case (it.op)
          OP_DOUT: out_lvl_r[2'd3 - it.ch[1:0]] <= it.high;
          OP_AOUT: ao_r <= it.value;
          OP_DIN: begin
            if (it.ch < 3'(NUM_AIN)) begin
              mode_r <= mode_r | (MODE_DI_MASK >> {it.ch[1:0], 1'b0});
            end
            if (take) begin
              in_lvl_r[3'(NUM_CH - 1) - it.ch] <= it.high;
            end
          end
          OP_AV: begin
            if (take) begin
              ai_r[it.ch[1:0]] <= it.value;
            end
          end
          OP_AI: begin
            mode_r <= mode_r | (MODE_AI_MASK >> {it.ch[1:0], 1'b0});
            if (take) begin
              ai_r[it.ch[1:0]] <= it.value;
            end
          end
          default: ;
        endcase
        if (take) begin
          never_r[it.ch] <= 1'b0;
          last_r[it.ch]  <= now_tb;
        end
      end
    end
  end

  // High-level event counters, one incrementer per lane.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_CH; i++) begin
      if (!rst_n) begin
        cnt_r[i] <= '0;
      end else if (go && (it.op == OP_DIN) && take && it.high && (it.ch == 3'(i))) begin
        cnt_r[i] <= cnt_r[i] + 1'b1;
      end
    end
  end

  // Frame byte position; returns to zero after the final byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fidx_r <= '0;
    end else if (go && is_read) begin
      fidx_r <= last_fbyte ? '0 : fidx_r + 1'b1;
    end
  end

  // Output register: loads on every step, holds while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      if (is_read) begin
        out_data_r.frame_byte      <= frame_img[fidx_r];
        out_data_r.last_byte       <= last_fbyte;
        out_data_r.updates_pending <= 1'b0;
        out_data_r.accepted        <= 1'b0;
      end else begin
        out_data_r.frame_byte      <= 8'd0;
        out_data_r.last_byte       <= 1'b1;
        out_data_r.updates_pending <= changed_nxt;
        out_data_r.accepted        <= acc;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/io_status_rate_limited_aggregator.sv
// ----------------------------------------------------------------------------
// I/O status rate-limited aggregator
// Keeps the status image of an I/O module, updates it from pin events under
// per-channel rate limits and sends the 25-byte status frame on request.
//
//   Channel  Direction  Handshake           Beat
//   in_      input      in_valid/in_stall   in_beat_t: command, pin, value, time
//   out_     output     out_valid/out_stall out_beat_t: one result per beat
//   cfg_     input      cfg_we              minimum interval of one channel
//
// A pin event is one back-end update step and gives one result beat; a frame
// read sends its 25 bytes, one per cycle from the output register while out_stall
// is low. The back end's single update step per cycle sets this rate. An input
// beat is registered in the queue, then in the output register, before its
// first result. Reset is synchronous and needs no clearing pass. Input and output
// stall separately: the two-entry queue keeps taking beats while a result waits.
// ----------------------------------------------------------------------------
module io_status_rate_limited_aggregator
  import iosra_pkg::*;
#(
  parameter int TIME_BITS    = TIME_BITS_DEF,
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_beat_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_beat_t          out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [IV_BITS-1:0] cfg_data
);

  logic [NUM_CH-1:0][IV_BITS-1:0] min_iv_r;
  head_t                          head;
  logic                           pop;

  // Minimum interval registers; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_iv_r <= '0;
    end else if (cfg_we && (cfg_index < 3'(NUM_CH))) begin
      min_iv_r[cfg_index] <= cfg_data;
    end
  end

  iosra_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .head     (head),
    .pop      (pop)
  );

  iosra_back #(
    .TIME_BITS    (TIME_BITS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .min_iv    (min_iv_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### sv/iosra_checker.sv
// ----------------------------------------------------------------------------
// I/O status aggregator port checker
// Watches the top-level ports and checks the result stream: held beats under
// stall and the field combinations that events and frame bytes may show.
// ----------------------------------------------------------------------------
`include "io_status_rate_limited_aggregator_defines.svh"

module iosra_checker
  import iosra_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  // A stalled result beat stays and does not change.
  `IOSRA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")

  // An accepted event is a single, final beat with no frame data.
  `IOSRA_ASSERT_IMPL(a_acc_event, out_valid && out_data.accepted, out_data.last_byte && (out_data.frame_byte == 8'd0), "accepted beat is not a plain event result")

  // An accepted event always leaves updates pending.
  `IOSRA_ASSERT_IMPL(a_acc_pending, out_valid && out_data.accepted, out_data.updates_pending, "accepted event without pending updates")

  // Beats before the end of a frame carry no event flags.
  `IOSRA_ASSERT_IMPL(a_frame_body, out_valid && !out_data.last_byte, !out_data.accepted && !out_data.updates_pending, "frame byte carries event flags")

endmodule

bind io_status_rate_limited_aggregator iosra_checker u_iosra_checker (.*);
